[sv/rmq_pkg.sv]
// shared constants and types for the rotation matrix to quaternion unit
package rmq_pkg;

    // threshold register
    localparam int          THR_W     = 21;
    localparam logic [20:0] THR_RESET = 21'd1024;

    // quaternion slot codes, also the axis picked for the half root
    typedef enum logic [1:0] {
        SLOT_X,
        SLOT_Y,
        SLOT_Z,
        SLOT_W
    } t_slot;

endpackage

[sv/rotation_matrix_to_quaternion_unit.sv]
// rotation matrix to unit quaternion, fully pipelined fixed point datapath
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    tdata: elem_0 .. elem_8
//  m_axis    out        m_axis_tvalid / m_axis_tready    tdata: quat_x .. quat_w, tuser: degenerate
//  cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_data: zero_threshold
//
// one beat enters per cycle while m_axis is not stalled; the pipeline depth is
// set by the one-digit-per-stage square root (DATA_WIDTH stages) and the
// one-bit-per-stage restoring reciprocal (2*(DATA_WIDTH-2) stages)
// a stall at m_axis freezes every stage at once, nothing is dropped or repeated
// synchronous active-low reset clears the valid bits and loads the threshold register with THR_RESET
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // elem_0 .. elem_8 from bit 0 up, zero padded to bytes
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w from bit 0 up, zero padded to bytes
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // degenerate
    output logic                                     m_axis_tuser,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [rmq_pkg::THR_W-1:0]                i_cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = W - 2;
    localparam int XW  = W + 3;                 // exact width for entry sums
    localparam int VW  = W + 1;                 // off-diagonal sums/differences
    localparam int QW  = 2 * F;                 // reciprocal quotient bits
    localparam int RW  = (QW > 63) ? 63 : QW;   // capped reciprocal width
    localparam int MW  = W + 1;                 // magnitude width
    localparam int ML  = (MW + 1) / 2;
    localparam int RL  = (RW + 1) / 2;
    localparam int PW  = MW + RW;
    localparam int CW  = (W > rmq_pkg::THR_W) ? W : rmq_pkg::THR_W;
    localparam int OW  = ((4*W+7)/8)*8;

    localparam logic signed [XW-1:0] QONE_X  = XW'(1) <<< F;
    localparam logic [W-1:0]         QONE    = W'(1) << F;
    localparam logic [W:0]           POS_LIM = (W+1)'((W+1)'(1) << (W-1)) - (W+1)'(1);
    localparam logic [PW:0]          POS_LIM_P = (PW+1)'(POS_LIM);
    localparam logic [PW:0]          NEG_LIM_P = (PW+1)'(1) << (W-1);

    typedef struct packed {
        logic [3:0][VW-1:0] val;
        rmq_pkg::t_slot     hsel;
        logic               is_trace;
    } t_item;

    // global advance: the whole pipe moves when the output slot is free or taken
    logic en;
    logic r_out_v;
    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    // threshold register
    logic [rmq_pkg::THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rmq_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // entry: trace, axis pick, root argument, component numerators
    // ---------------------------------------------------------------
    logic signed [XW-1:0] ex [9];
    logic signed [XW-1:0] n_tr;
    logic signed [XW-1:0] n_arg;
    rmq_pkg::t_slot       n_sel;
    t_item                n_item;
    logic [W:0]           n_a;

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            ex[n] = XW'($signed(s_axis_tdata[n*W +: W]));
        end
        n_tr = ex[0] + ex[4] + ex[8];
        if (n_tr > 0) begin
            n_sel = rmq_pkg::SLOT_W;
        end else if (ex[8] > ((ex[4] > ex[0]) ? ex[4] : ex[0])) begin
            n_sel = rmq_pkg::SLOT_Z;
        end else if (ex[4] > ex[0]) begin
            n_sel = rmq_pkg::SLOT_Y;
        end else begin
            n_sel = rmq_pkg::SLOT_X;
        end
        n_item.hsel     = n_sel;
        n_item.is_trace = (n_sel == rmq_pkg::SLOT_W);
        n_item.val      = '0;
        unique case (n_sel)
            rmq_pkg::SLOT_W: begin
                n_arg = n_tr + QONE_X;
                n_item.val[0] = VW'(ex[7] - ex[5]);
                n_item.val[1] = VW'(ex[2] - ex[6]);
                n_item.val[2] = VW'(ex[3] - ex[1]);
            end
            rmq_pkg::SLOT_X: begin
                n_arg = ex[0] - (ex[4] + ex[8]) + QONE_X;
                n_item.val[3] = VW'(ex[7] - ex[5]);
                n_item.val[1] = VW'(ex[1] + ex[3]);
                n_item.val[2] = VW'(ex[2] + ex[6]);
            end
            rmq_pkg::SLOT_Y: begin
                n_arg = ex[4] - (ex[8] + ex[0]) + QONE_X;
                n_item.val[3] = VW'(ex[2] - ex[6]);
                n_item.val[2] = VW'(ex[5] + ex[7]);
                n_item.val[0] = VW'(ex[1] + ex[3]);
            end
            rmq_pkg::SLOT_Z: begin
                n_arg = ex[8] - (ex[0] + ex[4]) + QONE_X;
                n_item.val[3] = VW'(ex[3] - ex[1]);
                n_item.val[0] = VW'(ex[2] + ex[6]);
                n_item.val[1] = VW'(ex[5] + ex[7]);
            end
        endcase
        // negative argument clamps to zero
        n_a = (n_arg < 0) ? '0 : n_arg[W:0];
    end

    // ---------------------------------------------------------------
    // square root, one result bit per stage
    // ---------------------------------------------------------------
    logic [2*W-1:0] r_sq_x    [W+1];
    logic [W-1:0]   r_sq_root [W+1];
    logic [W+1:0]   r_sq_rem  [W+1];
    t_item          r_sq_it   [W+1];
    logic           r_sq_v    [W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= s_axis_tvalid;
        end
        if (en) begin
            r_sq_x[0]    <= {1'b0, n_a, {F{1'b0}}};
            r_sq_root[0] <= '0;
            r_sq_rem[0]  <= '0;
            r_sq_it[0]   <= n_item;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        logic [W+3:0] n_rem2;
        logic [W+3:0] n_trial;
        always_comb begin
            n_rem2  = {r_sq_rem[k], r_sq_x[k][2*W-1 -: 2]};
            n_trial = {2'b00, r_sq_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            if (en) begin
                r_sq_x[k+1]  <= r_sq_x[k] << 2;
                r_sq_it[k+1] <= r_sq_it[k];
                if (n_rem2 >= n_trial) begin
                    r_sq_rem[k+1]  <= (W+2)'(n_rem2 - n_trial);
                    r_sq_root[k+1] <= {r_sq_root[k][W-2:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= n_rem2[W+1:0];
                    r_sq_root[k+1] <= {r_sq_root[k][W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // root done: zero test, half root, reciprocal setup
    // ---------------------------------------------------------------
    logic [W-1:0] r_dv_s    [QW+1];
    logic [W-1:0] r_dv_rem  [QW+1];
    logic [QW-1:0] r_dv_q   [QW+1];
    logic [W-1:0] r_dv_half [QW+1];
    logic         r_dv_deg  [QW+1];
    t_item        r_dv_it   [QW+1];
    logic         r_dv_v    [QW+1];

    logic [W:0]   n_h;
    logic         n_deg;
    always_comb begin
        n_h   = ((W+1)'(r_sq_root[W]) + (W+1)'(1)) >> 1;
        n_deg = !r_sq_it[W].is_trace && (CW'(r_sq_root[W]) <= CW'(r_thr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[W];
        end
        if (en) begin
            r_dv_s[0]    <= r_sq_root[W];
            r_dv_rem[0]  <= '0;
            r_dv_q[0]    <= '0;
            r_dv_half[0] <= (n_h > POS_LIM) ? POS_LIM[W-1:0] : n_h[W-1:0];
            r_dv_deg[0]  <= n_deg;
            r_dv_it[0]   <= r_sq_it[W];
        end
    end

    // restoring division of 2^(2F-1) by the root, one quotient bit per stage
    for (genvar t = 0; t < QW; t++) begin : g_div
        localparam logic LEAD = (t == 0);
        logic [W:0] n_rem2;
        always_comb begin
            n_rem2 = {r_dv_rem[t], LEAD};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[t+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[t+1] <= r_dv_v[t];
            end
            if (en) begin
                r_dv_s[t+1]    <= r_dv_s[t];
                r_dv_half[t+1] <= r_dv_half[t];
                r_dv_deg[t+1]  <= r_dv_deg[t];
                r_dv_it[t+1]   <= r_dv_it[t];
                if (n_rem2 >= {1'b0, r_dv_s[t]}) begin
                    r_dv_rem[t+1] <= W'(n_rem2 - {1'b0, r_dv_s[t]});
                    r_dv_q[t+1]   <= (r_dv_q[t] << 1) | QW'(1);
                end else begin
                    r_dv_rem[t+1] <= n_rem2[W-1:0];
                    r_dv_q[t+1]   <= r_dv_q[t] << 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // scaling: cap, magnitudes, split multiply, sum, round
    // ---------------------------------------------------------------
    logic [RW-1:0] n_rcap;
    if (QW > 62) begin : g_cap
        localparam logic [QW-1:0] CAP = QW'(1) << 62;
        assign n_rcap = (r_dv_q[QW] > CAP) ? RW'(CAP) : RW'(r_dv_q[QW]);
    end else begin : g_nocap
        assign n_rcap = r_dv_q[QW];
    end

    logic [RW-1:0]  r_m0_r;
    logic [MW-1:0]  r_m0_mag  [4];
    logic           r_m0_neg  [4];
    logic [W-1:0]   r_m0_half, r_m1_half, r_m2_half;
    logic           r_m0_deg, r_m1_deg, r_m2_deg;
    rmq_pkg::t_slot r_m0_hsel, r_m1_hsel, r_m2_hsel;
    logic           r_m0_v, r_m1_v, r_m2_v;
    logic [PW-1:0]  r_m1_pp   [4][4];
    logic           r_m1_neg  [4];
    logic [PW-1:0]  r_m2_p    [4];
    logic           r_m2_neg  [4];
    logic [W-1:0]   r_q       [4];
    logic           r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_v  <= 1'b0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_m0_v  <= r_dv_v[QW];
            r_m1_v  <= r_m0_v;
            r_m2_v  <= r_m1_v;
            r_out_v <= r_m2_v;
        end
        if (en) begin
            r_m0_r    <= n_rcap;
            r_m0_half <= r_dv_half[QW];
            r_m0_deg  <= r_dv_deg[QW];
            r_m0_hsel <= r_dv_it[QW].hsel;
            r_m1_half <= r_m0_half;
            r_m1_deg  <= r_m0_deg;
            r_m1_hsel <= r_m0_hsel;
            r_m2_half <= r_m1_half;
            r_m2_deg  <= r_m1_deg;
            r_m2_hsel <= r_m1_hsel;
            r_deg     <= r_m2_deg;
        end
    end

    for (genvar n = 0; n < 4; n++) begin : g_lane
        logic signed [VW-1:0] n_val;
        logic [PW:0]          n_rnd;
        logic [PW:0]          n_mag;
        logic [W-1:0]         n_res;
        always_comb begin
            n_val = $signed(r_dv_it[QW].val[n]);
            n_rnd = (PW+1)'(r_m2_p[n]) + ((PW+1)'(1) << (F-1));
            n_mag = n_rnd >> F;
            if (r_m2_neg[n]) begin
                n_res = -((n_mag > NEG_LIM_P) ? NEG_LIM_P[W-1:0] : n_mag[W-1:0]);
            end else begin
                n_res = (n_mag > POS_LIM_P) ? POS_LIM_P[W-1:0] : n_mag[W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m0_neg[n]   <= n_val < 0;
                r_m0_mag[n]   <= (n_val < 0) ? MW'(-n_val) : MW'(n_val);
                r_m1_neg[n]   <= r_m0_neg[n];
                r_m1_pp[n][0] <= PW'(r_m0_mag[n][ML-1:0]  * r_m0_r[RL-1:0]);
                r_m1_pp[n][1] <= PW'(r_m0_mag[n][ML-1:0]  * r_m0_r[RW-1:RL]);
                r_m1_pp[n][2] <= PW'(r_m0_mag[n][MW-1:ML] * r_m0_r[RL-1:0]);
                r_m1_pp[n][3] <= PW'(r_m0_mag[n][MW-1:ML] * r_m0_r[RW-1:RL]);
                r_m2_neg[n]   <= r_m1_neg[n];
                r_m2_p[n]     <= r_m1_pp[n][0] + (r_m1_pp[n][1] << RL)
                               + (r_m1_pp[n][2] << ML) + (r_m1_pp[n][3] << (ML + RL));
                // identity on a degenerate beat (root at or below the threshold), half root in the picked slot
                if (r_m2_deg) begin
                    r_q[n] <= (rmq_pkg::t_slot'(n) == rmq_pkg::SLOT_W) ? QONE : '0;
                end else if (r_m2_hsel == rmq_pkg::t_slot'(n)) begin
                    r_q[n] <= r_m2_half;
                end else begin
                    r_q[n] <= n_res;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OW'({r_q[3], r_q[2], r_q[1], r_q[0]});
    assign m_axis_tuser  = r_deg;

    // identity result whenever the flag is set
    a_deg_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (r_q[0] == '0 && r_q[1] == '0 && r_q[2] == '0 && r_q[3] == QONE))
        else $error("degenerate beat is not the identity");

    // a held output stalls the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // trace branch never reports degenerate
    a_trace_nondeg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[0] && r_dv_it[0].is_trace) |-> !r_dv_deg[0])
        else $error("trace branch flagged degenerate");

endmodule
